// ===== rtl/core/cdht_pkg.sv =====
// ----------------------------------------------------------------------------
// cdht_pkg: shared types and constants of the clock drift holdover tracker
// Command codes, status and holdover codes, register indices, controller
// states, and the command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package cdht_pkg;

    localparam int unsigned DIV_STEPS = 64;
    localparam logic [31:0] PPM_SCALE = 32'd1000000;
    localparam logic [63:0] MS_PER_S  = 64'd1000;

    typedef enum logic {
        CMD_OBSERVE  = 1'b0,
        CMD_EVALUATE = 1'b1
    } cmd_t;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_BAD_SRC = 2'd1,
        ST_RANGE   = 2'd2
    } status_t;

    typedef enum logic [1:0] {
        HS_INVALID = 2'd0,
        HS_EXPIRED = 2'd1,
        HS_FRESH   = 2'd2,
        HS_VALID   = 2'd3
    } hstate_t;

    typedef enum logic [2:0] {
        REG_OSC_BOUND = 3'd0,
        REG_MAX_DRIFT = 3'd1,
        REG_MAX_HOLD  = 3'd2,
        REG_GUARD     = 3'd3,
        REG_BUDGET    = 3'd4
    } reg_idx_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PREP,
        S_MUL,
        S_MUL_HI,
        S_DIV,
        S_FINISH,
        S_DONE
    } ctrl_state_t;

    // controller -> datapath
    typedef struct packed {
        logic load;     // capture input item
        logic prep;     // classify, form multiplier operands
        logic mul;      // low 32x32 partial product
        logic div_init; // high partial product, start the divider
        logic div_step; // one restoring step
        logic finish;   // final decision, state update, result register
    } dp_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic need_div; // item needs multiply and divide
        logic div_last; // last divider step this cycle
    } dp_stat_t;

endpackage

// ===== rtl/core/clock_drift_holdover_tracker_unit.sv =====
// ----------------------------------------------------------------------------
// clock_drift_holdover_tracker_unit: holdover tracker top level
// Controller plus datapath for drift tracking and holdover decisions.
// ----------------------------------------------------------------------------
// One transaction in, one result out. Every item takes a fixed path of
// capture, prepare and a multiply (one 32x32 multiplier, low then high
// half); an observe that measures drift and every evaluate that finds an
// observation made no later than its own time then run a 64-step restoring
// divider (one quotient bit per cycle) before finish. The divider sets the
// rate: items are handled one at a time, and a new item is taken the cycle
// after the result has been accepted on the master side. Configuration
// writes go straight to the registers and must only happen while the block
// is idle.
module clock_drift_holdover_tracker_unit (
    input  logic          aclk,
    input  logic          aresetn,
    // config
    input  logic          cfg_we,
    input  logic [2:0]    cfg_index,
    input  logic [63:0]   cfg_wdata,
    // input stream
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [191:0]  s_tdata,  // time_ms[63:0], offset[127:64],
                                    // meas_bound[191:128]
    input  logic [3:0]    s_tuser,  // cmd[0], source[3:1]
    // result stream
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [367:0]  m_tdata   // status[1:0], holdover_state[3:2],
                                    // tx_ok[4], age_ms[68:5],
                                    // err_bound[132:69], drift[196:133],
                                    // rate_lim[228:197],
                                    // current_source[231:229], rate_known[232],
                                    // expired_flag[233],
                                    // guard_need[297:234],
                                    // guard_left[361:298], zero above
);
    cdht_pkg::dp_cmd_t  cmd;
    cdht_pkg::dp_stat_t stat;

    logic        in_fire, out_fire;
    logic [1:0]  status, hstate;
    logic        tx, rknown, expd;
    logic [63:0] age, bound, req, remg;
    logic signed [63:0] drift;
    logic [31:0] rate;
    logic [2:0]  csrc;

    assign in_fire  = s_tvalid && s_tready;
    assign out_fire = m_tvalid && m_tready;

    cdht_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_fire   (in_fire),
        .out_fire  (out_fire),
        .stat      (stat),
        .cmd       (cmd),
        .in_ready  (s_tready),
        .out_valid (m_tvalid)
    );

    cdht_datapath u_dp (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cmd              (cmd),
        .stat             (stat),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_wdata        (cfg_wdata),
        .in_cmd           (s_tuser[0]),
        .in_source        (s_tuser[3:1]),
        .in_time_ms       (s_tdata[63:0]),
        .in_offs          (s_tdata[127:64]),
        .in_mbound_us     (s_tdata[191:128]),
        .o_status         (status),
        .o_hstate         (hstate),
        .o_tx_ok          (tx),
        .o_age_ms         (age),
        .o_err_bound      (bound),
        .o_drift          (drift),
        .o_rate_lim       (rate),
        .o_current_source (csrc),
        .o_rate_known     (rknown),
        .o_expired_flag   (expd),
        .o_guard_need     (req),
        .o_guard_left     (remg)
    );

    assign m_tdata = {6'd0, remg, req, expd, rknown, csrc, rate, drift, bound,
                      age, tx, hstate, status};

endmodule

// ===== rtl/core/cdht_ctrl.sv =====
// ----------------------------------------------------------------------------
// cdht_ctrl: sequencing controller
// Walks one transaction through prepare, multiply, divide (when needed) and
// finish, and holds the result until the master side takes it.
// ----------------------------------------------------------------------------
module cdht_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_fire,
    input  logic               out_fire,
    input  cdht_pkg::dp_stat_t stat,
    output cdht_pkg::dp_cmd_t  cmd,
    output logic               in_ready,
    output logic               out_valid
);
    cdht_pkg::ctrl_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= cdht_pkg::S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        in_ready   = 1'b0;
        out_valid  = 1'b0;
        unique case (state_reg)
            cdht_pkg::S_IDLE: begin
                in_ready = 1'b1;
                if (in_fire) begin
                    cmd.load   = 1'b1;
                    state_next = cdht_pkg::S_PREP;
                end
            end
            cdht_pkg::S_PREP: begin
                cmd.prep   = 1'b1;
                state_next = cdht_pkg::S_MUL;
            end
            cdht_pkg::S_MUL: begin
                cmd.mul    = 1'b1;
                state_next = cdht_pkg::S_MUL_HI;
            end
            cdht_pkg::S_MUL_HI: begin
                cmd.div_init = 1'b1;
                if (stat.need_div) begin
                    state_next = cdht_pkg::S_DIV;
                end else begin
                    state_next = cdht_pkg::S_FINISH;
                end
            end
            cdht_pkg::S_DIV: begin
                cmd.div_step = 1'b1;
                if (stat.div_last) begin
                    state_next = cdht_pkg::S_FINISH;
                end
            end
            cdht_pkg::S_FINISH: begin
                cmd.finish = 1'b1;
                state_next = cdht_pkg::S_DONE;
            end
            cdht_pkg::S_DONE: begin
                out_valid = 1'b1;
                if (out_fire) begin
                    state_next = cdht_pkg::S_IDLE;
                end
            end
            default: state_next = cdht_pkg::S_IDLE;
        endcase
    end

endmodule

// ===== rtl/core/cdht_datapath.sv =====
// ----------------------------------------------------------------------------
// cdht_datapath: tracker state, config registers and arithmetic
// One 32x32 multiplier forms the 64x32 product (low half, then high half
// accumulated), one restoring divider step per cycle, and the decision
// logic.
// ----------------------------------------------------------------------------
module cdht_datapath (
    input  logic               aclk,
    input  logic               aresetn,
    input  cdht_pkg::dp_cmd_t  cmd,
    output cdht_pkg::dp_stat_t stat,
    // config
    input  logic               cfg_we,
    input  logic [2:0]         cfg_index,
    input  logic [63:0]        cfg_wdata,
    // input item
    input  logic               in_cmd,
    input  logic [2:0]         in_source,
    input  logic [63:0]        in_time_ms,
    input  logic signed [63:0] in_offs,
    input  logic [63:0]        in_mbound_us,
    // result
    output logic [1:0]         o_status,
    output logic [1:0]         o_hstate,
    output logic               o_tx_ok,
    output logic [63:0]        o_age_ms,
    output logic [63:0]        o_err_bound,
    output logic signed [63:0] o_drift,
    output logic [31:0]        o_rate_lim,
    output logic [2:0]         o_current_source,
    output logic               o_rate_known,
    output logic               o_expired_flag,
    output logic [63:0]        o_guard_need,
    output logic [63:0]        o_guard_left
);
    // configuration
    logic [31:0] osc_bound_reg, max_drift_reg;
    logic [63:0] max_hold_reg, guard_reg, budget_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            osc_bound_reg <= 32'd20;
            max_drift_reg <= 32'd100;
            max_hold_reg  <= '0;
            guard_reg     <= '0;
            budget_reg    <= '0;
        end else if (cfg_we) begin
            unique case (cfg_index)
                cdht_pkg::REG_OSC_BOUND: osc_bound_reg <= cfg_wdata[31:0];
                cdht_pkg::REG_MAX_DRIFT: max_drift_reg <= cfg_wdata[31:0];
                cdht_pkg::REG_MAX_HOLD:  max_hold_reg  <= cfg_wdata;
                cdht_pkg::REG_GUARD:     guard_reg     <= cfg_wdata;
                cdht_pkg::REG_BUDGET:    budget_reg    <= cfg_wdata;
                default: ;
            endcase
        end
    end

    // tracker state
    logic        have_obs_reg, rate_valid_reg, expired_reg;
    logic [2:0]  src_reg;
    logic [63:0] last_time_reg, last_off_reg, base_bound_reg, meas_ppm_reg;

    // captured item
    logic        cmd_reg;
    logic [2:0]  isrc_reg;
    logic [63:0] itime_reg, ioff_reg, imb_reg;

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            cmd_reg   <= in_cmd;
            isrc_reg  <= in_source;
            itime_reg <= in_time_ms;
            ioff_reg  <= in_offs;
            imb_reg   <= in_mbound_us;
        end
    end

    // prepare: classify item, pick multiplier operands
    typedef enum logic [2:0] {
        K_BADSRC, K_BACK, K_RESTART, K_ZERO, K_DRIFT, K_NOOBS, K_EVAL
    } kind_t;

    kind_t       kind_reg, kind_c;
    logic        neg_reg;
    logic [63:0] wide_reg, age_reg;
    logic [31:0] narrow_reg, rate_reg;

    logic        neg_c;
    logic [63:0] mag_c, mrate_c, age_c;
    logic [31:0] rate_c;

    always_comb begin
        neg_c   = $signed(ioff_reg) < $signed(last_off_reg);
        mag_c   = neg_c ? last_off_reg - ioff_reg : ioff_reg - last_off_reg;
        age_c   = itime_reg - last_time_reg;
        mrate_c = meas_ppm_reg[63] ? 64'd0 - meas_ppm_reg : meas_ppm_reg;
        rate_c  = osc_bound_reg;
        if (mrate_c > {32'd0, osc_bound_reg}) begin
            rate_c = (mrate_c[63:32] != '0) ? '1 : mrate_c[31:0];
        end
        if (cmd_reg == cdht_pkg::CMD_OBSERVE) begin
            if (isrc_reg < 3'd1 || isrc_reg > 3'd5) begin
                kind_c = K_BADSRC;
            end else if (have_obs_reg && itime_reg < last_time_reg) begin
                kind_c = K_BACK;
            end else if (!have_obs_reg || isrc_reg != src_reg) begin
                kind_c = K_RESTART;
            end else if (age_c == '0) begin
                kind_c = K_ZERO;
            end else begin
                kind_c = K_DRIFT;
            end
        end else if (!have_obs_reg) begin
            kind_c = K_NOOBS;
        end else if (itime_reg < last_time_reg) begin
            kind_c = K_BACK;
        end else begin
            kind_c = K_EVAL;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.prep) begin
            kind_reg <= kind_c;
            neg_reg  <= neg_c;
            age_reg  <= age_c;
            rate_reg <= rate_c;
            if (kind_c == K_EVAL) begin
                wide_reg   <= age_c;
                narrow_reg <= rate_c;
            end else begin
                wide_reg   <= mag_c;
                narrow_reg <= cdht_pkg::PPM_SCALE;
            end
        end
    end

    assign stat.need_div = (kind_reg == K_DRIFT) || (kind_reg == K_EVAL);

    // multiply: 64x32 as two 32x32 steps; the high step adds onto the low one
    logic [31:0] mul_a_c;
    logic [63:0] pp_c, prod_lo_reg;
    logic [95:0] prod_c;
    always_comb begin
        mul_a_c = cmd.div_init ? wide_reg[63:32] : wide_reg[31:0];
        pp_c    = {32'd0, mul_a_c} * {32'd0, narrow_reg};
        prod_c  = {pp_c, 32'd0} + {32'd0, prod_lo_reg};
    end

    always_ff @(posedge aclk) begin
        if (cmd.mul) begin
            prod_lo_reg <= pp_c;
        end
    end

    // divider: hi:lo / d, restoring, one bit a cycle
    logic [63:0] div_d_c;
    assign div_d_c = (kind_reg == K_EVAL) ? cdht_pkg::MS_PER_S : age_reg;

    logic [63:0] rem_reg, lo_reg, quo_reg, dvs_reg;
    logic        dovf_reg;
    logic [5:0]  cnt_reg;

    logic        carry_c;
    logic [63:0] shl_c;
    always_comb begin
        carry_c = rem_reg[63];
        shl_c   = {rem_reg[62:0], lo_reg[63]};
    end

    always_ff @(posedge aclk) begin
        if (cmd.div_init) begin
            rem_reg  <= {32'd0, prod_c[95:64]};
            lo_reg   <= prod_c[63:0];
            dovf_reg <= ({32'd0, prod_c[95:64]} >= div_d_c);
            dvs_reg  <= div_d_c;
            quo_reg  <= '0;
            cnt_reg  <= '0;
        end else if (cmd.div_step) begin
            lo_reg  <= {lo_reg[62:0], 1'b0};
            cnt_reg <= cnt_reg + 6'd1;
            if (carry_c || shl_c >= dvs_reg) begin
                rem_reg <= shl_c - dvs_reg;
                quo_reg <= {quo_reg[62:0], 1'b1};
            end else begin
                rem_reg <= shl_c;
                quo_reg <= {quo_reg[62:0], 1'b0};
            end
        end
    end

    assign stat.div_last = (cnt_reg == 6'(cdht_pkg::DIV_STEPS - 1));

    // finish: decision and state update
    logic [63:0] growth_c, bound_c, req_c, rem_out_c;
    logic        budget_ok_c, tx_c, ovf_c;
    logic [63:0] ppm_c;
    always_comb begin
        if (dovf_reg) begin
            growth_c = '1;
        end else if (rem_reg != '0 && quo_reg != '1) begin
            growth_c = quo_reg + 64'd1;
        end else begin
            growth_c = quo_reg;
        end
        bound_c     = (base_bound_reg > ~growth_c) ? '1 : base_bound_reg + growth_c;
        budget_ok_c = bound_c <= ~budget_reg;
        req_c       = budget_ok_c ? bound_c + budget_reg : '1;
        tx_c        = !expired_reg && (age_reg <= max_hold_reg)
                      && budget_ok_c && (guard_reg >= req_c);
        rem_out_c   = guard_reg - req_c;
        ovf_c       = dovf_reg || (!neg_reg && quo_reg[63])
                      || (neg_reg && quo_reg > {1'b1, 63'd0});
        ppm_c       = neg_reg ? 64'd0 - quo_reg : quo_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            have_obs_reg   <= 1'b0;
            rate_valid_reg <= 1'b0;
            expired_reg    <= 1'b0;
            src_reg        <= '0;
            last_time_reg  <= '0;
            last_off_reg   <= '0;
            base_bound_reg <= '0;
            meas_ppm_reg   <= '0;
        end else if (cmd.finish) begin
            unique case (kind_reg)
                K_BACK: expired_reg <= 1'b1;
                K_RESTART: begin
                    last_time_reg  <= itime_reg;
                    last_off_reg   <= ioff_reg;
                    base_bound_reg <= imb_reg;
                    meas_ppm_reg   <= '0;
                    src_reg        <= isrc_reg;
                    have_obs_reg   <= 1'b1;
                    rate_valid_reg <= 1'b0;
                    expired_reg    <= 1'b0;
                end
                K_ZERO: expired_reg <= (ioff_reg != last_off_reg);
                K_DRIFT: begin
                    if (ovf_c) begin
                        expired_reg <= 1'b1;
                    end else begin
                        meas_ppm_reg   <= ppm_c;
                        rate_valid_reg <= 1'b1;
                        if (quo_reg > {32'd0, max_drift_reg}) begin
                            expired_reg <= 1'b1;
                        end else begin
                            last_time_reg  <= itime_reg;
                            last_off_reg   <= ioff_reg;
                            base_bound_reg <= imb_reg;
                            expired_reg    <= 1'b0;
                        end
                    end
                end
                default: ;
            endcase
        end
    end

    // result register (state fields read live from state registers)
    always_ff @(posedge aclk) begin
        if (cmd.finish) begin
            o_status     <= cdht_pkg::ST_OK;
            o_hstate     <= cdht_pkg::HS_INVALID;
            o_tx_ok      <= 1'b0;
            o_age_ms     <= '0;
            o_err_bound  <= '0;
            o_rate_lim   <= '0;
            o_guard_need <= '0;
            o_guard_left <= '0;
            unique case (kind_reg)
                K_BADSRC: o_status <= cdht_pkg::ST_BAD_SRC;
                K_BACK:   o_status <= cdht_pkg::ST_RANGE;
                K_ZERO: begin
                    if (ioff_reg != last_off_reg) o_status <= cdht_pkg::ST_RANGE;
                end
                K_DRIFT: begin
                    if (ovf_c || quo_reg > {32'd0, max_drift_reg}) begin
                        o_status <= cdht_pkg::ST_RANGE;
                    end
                end
                K_EVAL: begin
                    o_age_ms     <= age_reg;
                    o_err_bound  <= bound_c;
                    o_rate_lim   <= rate_reg;
                    o_guard_need <= req_c;
                    if (tx_c) begin
                        o_hstate <= (age_reg == '0) ? cdht_pkg::HS_FRESH
                                                    : cdht_pkg::HS_VALID;
                        o_tx_ok      <= 1'b1;
                        o_guard_left <= rem_out_c;
                    end else begin
                        o_hstate <= cdht_pkg::HS_EXPIRED;
                    end
                end
                default: ;
            endcase
        end
    end

    assign o_drift          = meas_ppm_reg;
    assign o_current_source = src_reg;
    assign o_rate_known     = rate_valid_reg;
    assign o_expired_flag   = expired_reg;

endmodule

// ===== rtl/core/cdht_checker.sv =====
// ----------------------------------------------------------------------------
// cdht_checker: port-level checks of the holdover tracker
// Watches handshakes and result encoding at the top-level ports.
// ----------------------------------------------------------------------------
module cdht_checker (
    input logic         aclk,
    input logic         aresetn,
    input logic         s_tvalid,
    input logic         s_tready,
    input logic         m_tvalid,
    input logic         m_tready,
    input logic [367:0] m_tdata
);
    // one item at a time: no input accepted while a result waits
    a_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> !s_tready)
        else $error("input ready while result pending");

    // an accepted input is not answered at once: no valid result right after it
    a_lat: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready) |=> !m_tvalid)
        else $error("result too early");

    // transmit permitted only with a fresh or valid state
    a_tx: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tdata[4]) |-> (m_tdata[3:2] == cdht_pkg::HS_FRESH
                                      || m_tdata[3:2] == cdht_pkg::HS_VALID))
        else $error("transmit permitted in bad state");

    // a stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("result changed while stalled");
endmodule

bind clock_drift_holdover_tracker_unit cdht_checker u_cdht_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

// ===== tb/tb_clock_drift_holdover_tracker_unit.sv =====
// ----------------------------------------------------------------------------
// tb_clock_drift_holdover_tracker_unit: self-checking bench of the tracker
// Drives observe/evaluate transactions and configuration phases, predicts
// every result with an independent behavioral model and compares each
// result stream transaction field by field, under varied backpressure.
// ----------------------------------------------------------------------------
module tb_clock_drift_holdover_tracker_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] MIN_NEG  = 64'h8000_0000_0000_0000;

    // one input transaction
    typedef struct {
        cdht_pkg::cmd_t cmd;
        logic [2:0]     source;
        logic [63:0]    time_ms;
        logic [63:0]    offs;
        logic [63:0]    mbound_us;
    } obs_item_t;

    // one result transaction
    typedef struct {
        cdht_pkg::status_t status;
        cdht_pkg::hstate_t hstate;
        logic              tx_ok;
        logic [63:0]       age_ms;
        logic [63:0]       err_bound;
        logic [63:0]       drift;
        logic [31:0]       rate_bound;
        logic [2:0]        cur_source;
        logic              rate_known;
        logic              expired;
        logic [63:0]       required;
        logic [63:0]       remaining;
    } decision_t;

    // Holdover predictor plus queue of pending decisions.
    class holdover_scoreboard;
        logic [63:0] osc_ppm, drift_lim, hold_lim, guard, budget;
        logic        have_obs, rate_ok, expired;
        logic [2:0]  src;
        logic [63:0] t_last, off_last, bound_base, ppm_meas;
        decision_t   pending[$];

        function new();
            osc_ppm = 20; drift_lim = 100; hold_lim = 0; guard = 0; budget = 0;
            have_obs = 0; rate_ok = 0; expired = 0; src = 0;
            t_last = 0; off_last = 0; bound_base = 0; ppm_meas = 0;
        endfunction

        function void set_reg(cdht_pkg::reg_idx_t idx, logic [63:0] v);
            case (idx)
                cdht_pkg::REG_OSC_BOUND: osc_ppm   = {32'd0, v[31:0]};
                cdht_pkg::REG_MAX_DRIFT: drift_lim = {32'd0, v[31:0]};
                cdht_pkg::REG_MAX_HOLD:  hold_lim  = v;
                cdht_pkg::REG_GUARD:     guard     = v;
                cdht_pkg::REG_BUDGET:    budget    = v;
                default: ;
            endcase
        endfunction

        function cdht_pkg::status_t observe(obs_item_t it);
            logic [63:0]  dt, mag, q, ppm;
            logic [127:0] quo;
            logic         neg;
            if (it.source < 1 || it.source > 5) return cdht_pkg::ST_BAD_SRC;
            if (have_obs && it.time_ms < t_last) begin
                expired = 1;
                return cdht_pkg::ST_RANGE;
            end
            // restart on first observation or source change
            if (!have_obs || it.source != src) begin
                t_last = it.time_ms; off_last = it.offs;
                bound_base = it.mbound_us; ppm_meas = 0; src = it.source;
                have_obs = 1; rate_ok = 0; expired = 0;
                return cdht_pkg::ST_OK;
            end
            dt = it.time_ms - t_last;
            if (dt == 0) begin
                expired = (it.offs != off_last);
                return expired ? cdht_pkg::ST_RANGE : cdht_pkg::ST_OK;
            end
            neg = $signed(it.offs) < $signed(off_last);
            mag = neg ? off_last - it.offs : it.offs - off_last;
            quo = ({64'd0, mag} * {96'd0, cdht_pkg::PPM_SCALE}) / {64'd0, dt};
            q = quo[63:0];
            if (quo[127:64] != 0 || (!neg && q[63]) || (neg && q > MIN_NEG)) begin
                expired = 1;
                return cdht_pkg::ST_RANGE;
            end
            ppm = neg ? -q : q;
            if (q > drift_lim) begin
                ppm_meas = ppm; rate_ok = 1; expired = 1;
                return cdht_pkg::ST_RANGE;
            end
            t_last = it.time_ms; off_last = it.offs; bound_base = it.mbound_us;
            ppm_meas = ppm; rate_ok = 1; expired = 0;
            return cdht_pkg::ST_OK;
        endfunction

        // accepted input: work out its decision
        function void note(obs_item_t it);
            decision_t    d;
            logic [63:0]  mrate, rate, growth;
            logic [127:0] prod, gq, gr;
            logic         budget_ok;
            d = '{status: cdht_pkg::ST_OK, hstate: cdht_pkg::HS_INVALID, default: '0};
            rate = 0;
            if (it.cmd == cdht_pkg::CMD_OBSERVE) begin
                d.status = observe(it);
            end else if (have_obs) begin
                if (it.time_ms < t_last) begin
                    expired = 1;
                    d.status = cdht_pkg::ST_RANGE;
                end else begin
                    d.age_ms = it.time_ms - t_last;
                    mrate = ppm_meas[63] ? -ppm_meas : ppm_meas;
                    rate = osc_ppm;
                    if (mrate > rate) rate = (mrate > 64'hFFFF_FFFF) ? 64'hFFFF_FFFF : mrate;
                    prod = {64'd0, rate} * {64'd0, d.age_ms};
                    gq = prod / 128'd1000;
                    gr = prod % 128'd1000;
                    if (gq[127:64] != 0) growth = ALL_ONES;
                    else begin
                        growth = gq[63:0];
                        if (gr != 0 && growth != ALL_ONES) growth++;
                    end
                    d.err_bound = (bound_base > ALL_ONES - growth) ? ALL_ONES
                                                                   : bound_base + growth;
                    budget_ok = d.err_bound <= ALL_ONES - budget;
                    d.required = budget_ok ? d.err_bound + budget : ALL_ONES;
                    if (expired || d.age_ms > hold_lim || !budget_ok || guard < d.required) begin
                        d.hstate = cdht_pkg::HS_EXPIRED;
                    end else begin
                        d.hstate = (d.age_ms == 0) ? cdht_pkg::HS_FRESH : cdht_pkg::HS_VALID;
                        d.remaining = guard - d.required;
                        d.tx_ok = 1;
                    end
                end
            end
            d.rate_bound = rate[31:0];
            d.drift      = ppm_meas;
            d.cur_source = src;
            d.rate_known = rate_ok;
            d.expired    = expired;
            pending.push_back(d);
        endfunction

        // returns a list of mismatching fields, empty when all match, or a note when none is pending
        function string check(decision_t got);
            decision_t exp_d;
            string     bad;
            bad = "";
            if (pending.size() == 0) return "result with no transaction pending";
            exp_d = pending.pop_front();
            if (got.status     != exp_d.status)     bad = {bad, " status"};
            if (got.hstate     != exp_d.hstate)     bad = {bad, " holdover_state"};
            if (got.tx_ok      != exp_d.tx_ok)      bad = {bad, " tx_ok"};
            if (got.age_ms     != exp_d.age_ms)     bad = {bad, " age_ms"};
            if (got.err_bound  != exp_d.err_bound)  bad = {bad, " err_bound"};
            if (got.drift      != exp_d.drift)      bad = {bad, " drift"};
            if (got.rate_bound != exp_d.rate_bound) bad = {bad, " rate_lim"};
            if (got.cur_source != exp_d.cur_source) bad = {bad, " current_source"};
            if (got.rate_known != exp_d.rate_known) bad = {bad, " rate_known"};
            if (got.expired    != exp_d.expired)    bad = {bad, " expired_flag"};
            if (got.required   != exp_d.required)   bad = {bad, " guard_need"};
            if (got.remaining  != exp_d.remaining)  bad = {bad, " guard_left"};
            if (bad != "") bad = {"field mismatch:", bad};
            return bad;
        endfunction
    endclass

    logic         aclk = 0;
    logic         aresetn = 0;
    logic         cfg_we = 0;
    logic [2:0]   cfg_index = '0;
    logic [63:0]  cfg_wdata = '0;
    logic         s_tvalid = 0;
    logic         s_tready;
    logic [191:0] s_tdata = '0;
    logic [3:0]   s_tuser = '0;
    logic         m_tvalid;
    logic         m_tready = 0;
    logic [367:0] m_tdata;

    holdover_scoreboard sb = new();
    int unsigned err_count = 0;
    int unsigned send_idle_pct = 0;   // sender gap probability, percent
    int unsigned recv_stall_pct = 0;  // receiver stall probability, percent
    int unsigned n_results = 0;

    // stimulus shaping state: rough copy of what is being tracked
    logic [2:0]  gen_src = 1;
    logic [63:0] gen_t = 0;
    logic [63:0] gen_off = 0;

    clock_drift_holdover_tracker_unit i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always begin
        #5 aclk = 1;
        #5 aclk = 0;
    end

    task automatic report(string msg);
        $display("[%0t] ERROR: %s", $time, msg);
        err_count++;
    endtask

    // receiver backpressure, re-rolled every cycle
    always @(posedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // result monitor: values seen here are the pre-edge ones
    always @(posedge aclk) begin
        decision_t got;
        string     msg;
        if (aresetn && m_tvalid && m_tready) begin
            got.status     = cdht_pkg::status_t'(m_tdata[1:0]);
            got.hstate     = cdht_pkg::hstate_t'(m_tdata[3:2]);
            got.tx_ok      = m_tdata[4];
            got.age_ms     = m_tdata[68:5];
            got.err_bound  = m_tdata[132:69];
            got.drift      = m_tdata[196:133];
            got.rate_bound = m_tdata[228:197];
            got.cur_source = m_tdata[231:229];
            got.rate_known = m_tdata[232];
            got.expired    = m_tdata[233];
            got.required   = m_tdata[297:234];
            got.remaining  = m_tdata[361:298];
            n_results++;
            msg = sb.check(got);
            if (msg != "") report($sformatf("result %0d: %s", n_results, msg));
        end
    end

    function automatic logic [63:0] rand64();
        return {$urandom, $urandom};
    endfunction

    // one input transaction; valid stays high across back-to-back items
    task automatic send_item(obs_item_t it);
        if ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 0;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
        s_tvalid <= 1;
        s_tuser  <= {it.source, it.cmd};
        s_tdata  <= {it.mbound_us, it.offs, it.time_ms};
        do @(posedge aclk); while (!s_tready);
        sb.note(it);
    endtask

    task automatic send(cdht_pkg::cmd_t c, logic [2:0] s, logic [63:0] t,
                        logic [63:0] o, logic [63:0] b);
        obs_item_t it;
        it = '{cmd: c, source: s, time_ms: t, offs: o, mbound_us: b};
        send_item(it);
    endtask

    // wait for every pending result, then a little slack for the block
    task automatic drain();
        s_tvalid <= 0;
        @(posedge aclk);
        while (sb.pending.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // program all registers while idle
    task automatic configure(logic [63:0] osc, logic [63:0] lim, logic [63:0] hold,
                             logic [63:0] grd, logic [63:0] bud);
        logic [63:0] vals[5];
        vals = '{osc, lim, hold, grd, bud};
        drain();
        for (int i = 0; i < 5; i++) begin
            cfg_we    <= 1;
            cfg_index <= 3'(i);
            cfg_wdata <= vals[i];
            @(posedge aclk);
            sb.set_reg(cdht_pkg::reg_idx_t'(i), vals[i]);
        end
        cfg_we <= 0;
        @(posedge aclk);
    endtask

    // extremes now and then, mostly moderate values
    function automatic logic [63:0] pick(logic [63:0] lo_v, logic [63:0] hi_v,
                                         int unsigned span);
        int unsigned r;
        r = $urandom_range(9);
        if (r == 0) return lo_v;
        if (r == 1) return hi_v;
        if (r == 2) return rand64() | lo_v;
        return lo_v + $urandom_range(span);
    endfunction

    task automatic random_config();
        configure(pick(1, 64'hFFFF_FFFF, 400), pick(1, 64'hFFFF_FFFF, 3000),
                  pick(0, ALL_ONES, 30000), pick(0, ALL_ONES, 2000000),
                  pick(0, ALL_ONES, 5000));
    endtask

    // Random item: mostly coherent observe/evaluate sequences, some noise.
    task automatic random_item();
        obs_item_t   it;
        int unsigned r;
        logic [63:0] dt, span;
        r = $urandom_range(99);
        it = '{cmd: cdht_pkg::CMD_OBSERVE, source: gen_src, time_ms: gen_t, offs: gen_off,
               mbound_us: 64'($urandom_range(2000))};
        if (r < 8) begin
            // noise: every bit of every field
            it.cmd = cdht_pkg::cmd_t'($urandom_range(1));
            it.source = 3'($urandom_range(7));
            it.time_ms = rand64();
            it.offs = rand64();
            it.mbound_us = rand64();
        end else if (r < 18) begin
            // source change restarts tracking
            gen_src = 3'($urandom_range(1, 5));
            it.source = gen_src;
            it.time_ms = ($urandom_range(19) == 0) ? rand64() : gen_t + $urandom_range(50);
            it.offs = 64'($signed($urandom_range(2000)) - 1000);
        end else if (r < 55) begin
            // same source, drift near the configured limit
            dt = 64'($urandom_range(1, 5000));
            span = (dt * (sb.drift_lim > 64'd100000000 ? 64'd100000000 : sb.drift_lim))
                   / 64'd500000 + 1;
            it.time_ms = gen_t + dt;
            it.offs = gen_off + ($urandom_range(1) ? span : -span)
                      - 64'($urandom_range(31'(span)));
        end else if (r < 62) begin
            // zero interval or time going backwards
            it.time_ms = $urandom_range(1) ? gen_t : gen_t - $urandom_range(1, 100);
            it.offs = gen_off + $urandom_range(1);
        end else begin
            it.cmd = cdht_pkg::CMD_EVALUATE;
            it.source = 3'($urandom_range(7));
            it.time_ms = ($urandom_range(15) == 0) ? gen_t - 1 : gen_t + $urandom_range(20000);
        end
        if (it.cmd == cdht_pkg::CMD_OBSERVE && it.source >= 1 && it.source <= 5) begin
            gen_src = it.source;
            gen_t = it.time_ms;
            gen_off = it.offs;
        end
        send_item(it);
    endtask

    task automatic directed();
        configure(20, 100, 10000, 1000000, 100);
        send(cdht_pkg::CMD_EVALUATE, 1, 500, 0, 0);     // evaluate before any observation
        send(cdht_pkg::CMD_OBSERVE, 0, 1000, 0, 0);     // monotonic source is invalid
        send(cdht_pkg::CMD_OBSERVE, 7, 1000, 0, 0);     // out-of-range source
        send(cdht_pkg::CMD_OBSERVE, 1, 1000, 0, 50);    // first observation
        send(cdht_pkg::CMD_OBSERVE, 1, 1000, 0, 60);    // zero interval, same offset
        send(cdht_pkg::CMD_OBSERVE, 1, 1000, 5, 60);    // zero interval, offset moved
        send(cdht_pkg::CMD_OBSERVE, 1, 2000, 0, 40);    // zero drift clears expiry
        send(cdht_pkg::CMD_OBSERVE, 1, 3000, 1, 40);    // drift over the limit
        send(cdht_pkg::CMD_EVALUATE, 3, 2000, 0, 0);    // expired decision
        send(cdht_pkg::CMD_OBSERVE, 1, 3000, 0, 40);    // back within limit
        send(cdht_pkg::CMD_EVALUATE, 1, 3000, 0, 0);    // age zero: fresh
        send(cdht_pkg::CMD_EVALUATE, 6, 5000, 0, 0);    // aged: valid
        send(cdht_pkg::CMD_EVALUATE, 1, 100, 0, 0);     // evaluate in the past
        send(cdht_pkg::CMD_OBSERVE, 1, 50, 0, 0);       // observe in the past
        send(cdht_pkg::CMD_OBSERVE, 2, 0, MIN_NEG, 0);  // restart at most negative offset
        send(cdht_pkg::CMD_OBSERVE, 2, 1, 64'h7FFF_FFFF_FFFF_FFFF, 0); // drift overflow
        send(cdht_pkg::CMD_OBSERVE, 4, 0, 0, 10);
        send(cdht_pkg::CMD_OBSERVE, 4, 1000, -64'sd50, 10); // negative drift above limit
        send(cdht_pkg::CMD_EVALUATE, 4, ALL_ONES, 0, 0);    // huge age
        send(cdht_pkg::CMD_OBSERVE, 3, 0, 0, ALL_ONES);     // saturated base bound
        send(cdht_pkg::CMD_EVALUATE, 3, ALL_ONES, 0, 0);    // growth and budget overflow
        configure(64'hFFFF_FFFF, 64'hFFFF_FFFF, ALL_ONES, ALL_ONES, 0);
        send(cdht_pkg::CMD_OBSERVE, 5, 0, 0, 0);
        send(cdht_pkg::CMD_OBSERVE, 5, 1, 64'd5000000, 0);  // drift beyond 32 bits, clamp
        send(cdht_pkg::CMD_EVALUATE, 5, 1000, 0, 0);
        send(cdht_pkg::CMD_EVALUATE, 5, 1, 0, 0);
    endtask

    initial begin
        int unsigned idle_modes[4][2];
        idle_modes = '{'{0, 0}, '{65, 0}, '{0, 65}, '{29, 29}};
        repeat (4) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);
        directed();
        // four backpressure modes, two register settings each
        for (int ph = 0; ph < 8; ph++) begin
            send_idle_pct  = idle_modes[ph / 2][0];
            recv_stall_pct = idle_modes[ph / 2][1];
            if (ph == 7) configure(1, 1, 0, 0, ALL_ONES);
            else random_config();
            for (int n = 0; n < 178; n++) begin
                // sender holds off until the block has drained
                if (ph == 3 && n == 90) drain();
                random_item();
            end
        end
        drain();
        repeat (80) @(posedge aclk);
        if (err_count == 0 && sb.pending.size() == 0) begin
            $display("tb_clock_drift_holdover_tracker_unit: PASS");
        end else begin
            $display("tb_clock_drift_holdover_tracker_unit: FAIL");
        end
        $finish;
    end

    // watchdog
    initial begin
        #20_000_000;
        $display("tb_clock_drift_holdover_tracker_unit: FAIL");
        $finish;
    end

endmodule
